// ----- design/sasmd_pkg.sv -----
// ----------------------------------------------------------------------------
// sasmd_pkg: shared types and constants for the signed add/sub/mul/div unit
// Payload structs, operation codes and default widths.
// ----------------------------------------------------------------------------
package sasmd_pkg;

  localparam int unsigned DEFAULT_WIDTH = 64;
  localparam int unsigned FIELD_W       = 64;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_kind_t;

  typedef struct packed {
    logic [1:0]          kind;
    logic signed [63:0]  operand_a;
    logic signed [63:0]  operand_b;
  } in_item_t;

  typedef struct packed {
    logic signed [63:0]  result;
    logic [63:0]         remainder;
  } out_item_t;

endpackage

// ----- design/signed_add_sub_mul_div_unit.sv -----
// ----------------------------------------------------------------------------
// signed_add_sub_mul_div_unit: pipelined signed ALU
// Saturating add/subtract, radix-2 Booth multiply, restoring divide.
// ----------------------------------------------------------------------------
// One operation enters per cycle while the output register is empty or being
// taken; each result passes through an input register that prepares operands,
// one pipeline stage per Booth or division step (WIDTH stages), and an output
// register that finishes the quotient sign and formats the fields. The whole pipe
// advances together whenever the output register is empty or being taken,
// so a stall holds every stage in place without loss or repetition.
module signed_add_sub_mul_div_unit import sasmd_pkg::*; #(
  parameter int unsigned WIDTH = DEFAULT_WIDTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam logic [WIDTH-1:0] MAXPOS = {1'b0, {(WIDTH-1){1'b1}}};

  logic adv;
  logic out_vld_r;
  out_item_t out_r, out_nxt;

  // Advance everything when the output slot frees up.
  assign adv      = !out_vld_r || out_ready;
  assign in_ready = adv;

  logic [WIDTH-1:0] a_w, b_w, s_add, nb;
  logic [WIDTH-1:0] add_res;

  always_comb begin
    a_w   = in_data.operand_a[WIDTH-1:0];
    b_w   = in_data.operand_b[WIDTH-1:0];
    nb    = (in_data.kind == OP_SUB) ? (~b_w + 1'b1) : b_w;
    s_add = a_w + nb;
    if ((a_w[WIDTH-1] == nb[WIDTH-1]) && (s_add[WIDTH-1] != a_w[WIDTH-1]))
      add_res = MAXPOS;
    else
      add_res = s_add;
  end

  // Stage array: index 0 is the input register, WIDTH is after the last step.
  logic             vld  [WIDTH+1];
  logic [1:0]       kind [WIDTH+1];
  logic [WIDTH-1:0] acc  [WIDTH+1];
  logic [WIDTH-1:0] q    [WIDTH+1];
  logic [WIDTH-1:0] m    [WIDTH+1];
  logic             prev [WIDTH+1];
  logic             sneg [WIDTH+1];

  logic             vld0_r, prev0_r, sneg0_r;
  logic [1:0]       kind0_r;
  logic [WIDTH-1:0] acc0_r, q0_r, m0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) vld0_r <= 1'b0;
    else if (adv) vld0_r <= in_valid;
    if (adv) begin
      kind0_r <= in_data.kind;
      prev0_r <= 1'b0;
      sneg0_r <= a_w[WIDTH-1] ^ b_w[WIDTH-1];
      unique case (in_data.kind)
        OP_ADD, OP_SUB: begin
          acc0_r <= add_res;
          q0_r   <= add_res;
          m0_r   <= '0;
        end
        OP_MUL: begin
          acc0_r <= '0;
          q0_r   <= a_w;
          m0_r   <= b_w;
        end
        default: begin
          acc0_r <= '0;
          q0_r   <= a_w[WIDTH-1] ? (~a_w + 1'b1) : a_w;
          m0_r   <= b_w[WIDTH-1] ? (~b_w + 1'b1) : b_w;
        end
      endcase
    end
  end

  assign vld[0]  = vld0_r;
  assign kind[0] = kind0_r;
  assign acc[0]  = acc0_r;
  assign q[0]    = q0_r;
  assign m[0]    = m0_r;
  assign prev[0] = prev0_r;
  assign sneg[0] = sneg0_r;

  // Add and subtract ride along; each step still computes on them, and a
  // pass-through register beside the step carries their result unchanged.
  for (genvar i = 0; i < WIDTH; i++) begin : g_step
    logic [1:0] k_eff;
    logic [WIDTH-1:0] acc_o, q_o;
    logic             alu_pass;
    assign alu_pass = (kind[i] == OP_ADD) || (kind[i] == OP_SUB);
    sasmd_step #(.WIDTH(WIDTH)) u_step (
      .clk(clk), .rst_n(rst_n), .adv(adv),
      .in_vld(vld[i]), .in_kind(kind[i]), .in_acc(acc[i]), .in_q(q[i]),
      .in_m(m[i]), .in_prev(prev[i]), .in_sneg(sneg[i]),
      .out_vld(vld[i+1]), .out_kind(k_eff), .out_acc(acc_o), .out_q(q_o),
      .out_m(m[i+1]), .out_prev(prev[i+1]), .out_sneg(sneg[i+1])
    );
    // Pass-through register for add/subtract results alongside the step.
    logic [WIDTH-1:0] hold_r;
    logic             pass_r;
    always_ff @(posedge clk) begin
      if (adv) begin
        hold_r <= q[i];
        pass_r <= alu_pass;
      end
    end
    assign kind[i+1] = k_eff;
    assign acc[i+1]  = pass_r ? hold_r : acc_o;
    assign q[i+1]    = pass_r ? hold_r : q_o;
  end

  logic [WIDTH-1:0] fin_q;
  always_comb begin
    fin_q   = q[WIDTH];
    out_nxt = '0;
    if (kind[WIDTH] == OP_DIV) begin
      if (sneg[WIDTH]) fin_q = ~q[WIDTH] + 1'b1;
      out_nxt.remainder = FIELD_W'(acc[WIDTH]);
    end
    out_nxt.result = FIELD_W'($signed(fin_q));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_vld_r <= 1'b0;
    else if (adv) out_vld_r <= vld[WIDTH];
    if (adv) out_r <= out_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  // Hold the result while the consumer stalls.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed during stall");
  // Remainder is zero except for divide.
  a_rem: assert property (@(posedge clk) disable iff (!rst_n)
    adv && vld[WIDTH] && kind[WIDTH] != OP_DIV |=> out_data.remainder == '0)
    else $error("nonzero remainder on non-divide");
  // Ready follows output slot occupancy.
  a_rdy: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("stalled with empty output");

endmodule

// ----- design/sasmd_step.sv -----
// ----------------------------------------------------------------------------
// sasmd_step: one registered stage of the iterative datapath
// Performs one Booth or restoring-division step with the saturating adder.
// ----------------------------------------------------------------------------
module sasmd_step import sasmd_pkg::*; #(
  parameter int unsigned WIDTH = DEFAULT_WIDTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic             in_vld,
  input  logic [1:0]       in_kind,
  input  logic [WIDTH-1:0] in_acc,
  input  logic [WIDTH-1:0] in_q,
  input  logic [WIDTH-1:0] in_m,
  input  logic             in_prev,
  input  logic             in_sneg,
  output logic             out_vld,
  output logic [1:0]       out_kind,
  output logic [WIDTH-1:0] out_acc,
  output logic [WIDTH-1:0] out_q,
  output logic [WIDTH-1:0] out_m,
  output logic             out_prev,
  output logic             out_sneg
);

  localparam logic [WIDTH-1:0] MAXPOS = {1'b0, {(WIDTH-1){1'b1}}};

  function automatic logic [WIDTH-1:0] add_sat(input logic [WIDTH-1:0] x,
                                               input logic [WIDTH-1:0] y);
    logic [WIDTH-1:0] s;
    s = x + y;
    if ((x[WIDTH-1] == y[WIDTH-1]) && (s[WIDTH-1] != x[WIDTH-1])) return MAXPOS;
    return s;
  endfunction

  logic             vld_r;
  logic [1:0]       kind_r;
  logic [WIDTH-1:0] acc_r, q_r, m_r, acc_nxt, q_nxt;
  logic             prev_r, prev_nxt, sneg_r;
  logic [WIDTH-1:0] a1, t, neg_m;

  always_comb begin
    neg_m    = ~in_m + 1'b1;
    acc_nxt  = in_acc;
    q_nxt    = in_q;
    prev_nxt = in_prev;
    a1       = in_acc;
    t        = '0;
    if (in_kind == OP_MUL) begin
      if (in_q[0] && !in_prev) a1 = add_sat(in_acc, neg_m);
      else if (!in_q[0] && in_prev) a1 = add_sat(in_acc, in_m);
      prev_nxt = in_q[0];
      acc_nxt  = {a1[WIDTH-1], a1[WIDTH-1:1]};
      q_nxt    = {a1[0], in_q[WIDTH-1:1]};
    end else begin
      t     = add_sat({in_acc[WIDTH-2:0], in_q[WIDTH-1]}, neg_m);
      q_nxt = {in_q[WIDTH-2:0], 1'b0};
      if (t[WIDTH-1]) acc_nxt = add_sat(t, in_m);
      else begin
        acc_nxt  = t;
        q_nxt[0] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else if (adv) vld_r <= in_vld;
    if (adv) begin
      kind_r <= in_kind;
      acc_r  <= acc_nxt;
      q_r    <= q_nxt;
      m_r    <= in_m;
      prev_r <= prev_nxt;
      sneg_r <= in_sneg;
    end
  end

  assign out_vld  = vld_r;
  assign out_kind = kind_r;
  assign out_acc  = acc_r;
  assign out_q    = q_r;
  assign out_m    = m_r;
  assign out_prev = prev_r;
  assign out_sneg = sneg_r;

endmodule
